[rtl/cbf_pkg.sv]
// Package for the circular byte FIFO: item structs, command codes and
// default sizes. Used by circular_byte_fifo_top.sv; depends on nothing.
package cbf_pkg;

    localparam int BUFFER_BYTES_DEF = 4096;
    localparam int COUNT_W          = 3;
    localparam int STORED_W         = 13;

    localparam logic [COUNT_W-1:0] MAX_BYTES = 3'd4;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               command;
        logic [31:0]        data_word;
        logic [COUNT_W-1:0] byte_count;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0]  accepted_count;
        logic [31:0]         read_data;
        logic                underflow;
        logic [STORED_W-1:0] stored_bytes;
    } t_out_item;

endpackage

[rtl/circular_byte_fifo_top.sv]
// Circular byte FIFO: push up to 4 bytes, pop up to 4 bytes, or clear.
// Bytes live in one RAM with one write and one read port, moved one byte per cycle.
// An item is accepted only in idle; a push or pop then moves its bytes and the
// result is registered on delivery. The next item is taken while a result waits
// on a stalled output.
// Reset empties the buffer; RAM contents are not cleared.
module circular_byte_fifo_top
    import cbf_pkg::*;
#(
    parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int FW = $clog2(BUFFER_BYTES + 1);
    localparam logic [AW:0]   DEPTH_C = (AW+1)'(BUFFER_BYTES);
    localparam logic [AW-1:0] LAST_C  = AW'(BUFFER_BYTES - 1);
    localparam logic [FW-1:0] FULL_C  = FW'(BUFFER_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PUSH = 4'b0010,
        ST_POP  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // control state
    t_state             r_state, n_state;
    logic [AW-1:0]      r_rd_pos, n_rd_pos;
    logic [AW-1:0]      r_wr_pos, n_wr_pos;
    logic [FW-1:0]      r_fill, n_fill;
    logic [COUNT_W-1:0] r_idx, n_idx;
    logic               r_pend, n_pend;
    logic               r_out_valid, n_out_valid;

    // payload working registers
    logic [AW-1:0]      r_addr, n_addr;
    logic [31:0]        r_word, n_word;
    logic [31:0]        r_data, n_data;
    logic [COUNT_W-1:0] r_done, n_done;
    logic [1:0]         r_lane, n_lane;
    logic               r_under, n_under;
    t_out_item          r_out_item, n_out_item;

    // RAM port signals
    logic               ram_we, ram_re;
    logic [7:0]         ram_rdata;

    // accept-time decode
    logic               in_acc;
    logic [COUNT_W-1:0] cnt_sat;
    logic [FW-1:0]      cnt_ext, room;
    logic [COUNT_W-1:0] push_n;
    logic [AW:0]        rd_sum, wr_sum;
    logic [AW-1:0]      addr_inc;
    logic               out_free;

    assign in_acc   = i_in_valid && (r_state == ST_IDLE);
    assign cnt_sat  = (i_in_item.byte_count > MAX_BYTES) ? MAX_BYTES : i_in_item.byte_count;
    assign cnt_ext  = FW'(cnt_sat);
    assign room     = FULL_C - r_fill;
    assign push_n   = (cnt_ext < room) ? cnt_sat : COUNT_W'(room);
    assign addr_inc = (r_addr == LAST_C) ? '0 : r_addr + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;

    // pointer advance with a single wrap correction
    always_comb begin
        rd_sum = {1'b0, r_rd_pos} + (AW+1)'(cnt_sat);
        if (rd_sum >= DEPTH_C) begin
            rd_sum = rd_sum - DEPTH_C;
        end
        wr_sum = {1'b0, r_wr_pos} + (AW+1)'(push_n);
        if (wr_sum >= DEPTH_C) begin
            wr_sum = wr_sum - DEPTH_C;
        end
    end

    // sequencer: accept, move bytes through the RAM, deliver result
    always_comb begin
        n_state     = r_state;
        n_rd_pos    = r_rd_pos;
        n_wr_pos    = r_wr_pos;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_addr      = r_addr;
        n_word      = r_word;
        n_data      = r_data;
        n_done      = r_done;
        n_lane      = r_lane;
        n_under     = r_under;
        n_out_item  = r_out_item;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx   = '0;
                    n_word  = i_in_item.data_word;
                    n_data  = '0;
                    n_done  = '0;
                    n_under = 1'b0;
                    n_state = ST_DONE;
                    unique case (i_in_item.command)
                        CMD_PUSH: begin
                            n_done   = push_n;
                            n_addr   = r_wr_pos;
                            n_wr_pos = wr_sum[AW-1:0];
                            n_fill   = r_fill + FW'(push_n);
                            if (push_n != '0) begin
                                n_state = ST_PUSH;
                            end
                        end
                        CMD_POP: begin
                            if (cnt_ext > r_fill) begin
                                n_under = 1'b1;
                            end else begin
                                n_done   = cnt_sat;
                                n_addr   = r_rd_pos;
                                n_rd_pos = rd_sum[AW-1:0];
                                n_fill   = r_fill - cnt_ext;
                                if (cnt_sat != '0) begin
                                    n_state = ST_POP;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_rd_pos = '0;
                            n_wr_pos = '0;
                            n_fill   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PUSH: begin
                // one byte written per cycle, low byte first
                ram_we = 1'b1;
                n_word = {8'd0, r_word[31:8]};
                n_addr = addr_inc;
                n_idx  = r_idx + 1'b1;
                if (n_idx == r_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_POP: begin
                // issue reads, gather each byte in the cycle after its read
                if (r_idx != r_done) begin
                    ram_re = 1'b1;
                    n_pend = 1'b1;
                    n_lane = r_idx[1:0];
                    n_addr = addr_inc;
                    n_idx  = r_idx + 1'b1;
                end
                if (r_pend) begin
                    n_data[r_lane*8 +: 8] = ram_rdata;
                    if (r_idx == r_done) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_item.accepted_count = r_done;
                    n_out_item.read_data      = r_data;
                    n_out_item.underflow      = r_under;
                    n_out_item.stored_bytes   = STORED_W'(r_fill);
                    n_out_valid               = 1'b1;
                    n_state                   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_pos    <= '0;
            r_wr_pos    <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_pos    <= n_rd_pos;
            r_wr_pos    <= n_wr_pos;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_word     <= n_word;
        r_data     <= n_data;
        r_done     <= n_done;
        r_lane     <= n_lane;
        r_under    <= n_under;
        r_out_item <= n_out_item;
    end

    // byte storage
    cbf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (r_word[7:0]),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[rtl/cbf_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
